/* hw/rtl/tevs_pkg.sv */
// Shared types, message constants and varint helpers for the touch event serializer.
package tevs_pkg;

  localparam int unsigned HDR_LEN   = 7;
  localparam int unsigned MID_LEN   = 5;
  localparam int unsigned TAIL_LEN  = 6;

  localparam logic [7:0] HDR_BYTES [HDR_LEN] = '{
    8'h02, 8'h0b, 8'h03, 8'h00, 8'h80, 8'h01, 8'h08
  };

  // Tag and zero varint of the third field, then the postamble; the action byte follows.
  localparam logic [7:0] TAIL_BYTES [TAIL_LEN - 1] = '{
    8'h18, 8'h00, 8'h10, 8'h00, 8'h18
  };

  localparam logic [7:0] MSG_ID        = 8'h1a;
  localparam logic [7:0] SUB_ID        = 8'h0a;
  localparam logic [7:0] LEN1_BASE     = 8'h09;
  localparam logic [7:0] LEN2_BASE     = 8'h03;
  localparam logic [7:0] TAG_X         = 8'h08;
  localparam logic [7:0] TAG_Y         = 8'h10;
  localparam logic [7:0] ZERO_VINT_LEN = 8'h01;

  typedef struct packed {
    logic [1:0]  action;
    logic [15:0] x_pos;
    logic [15:0] y_pos;
    logic [29:0] timestamp_ns;
  } event_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [39:0] ts_bytes;
    logic [2:0]  ts_len;
    logic [23:0] x_bytes;
    logic [1:0]  x_len;
    logic [23:0] y_bytes;
    logic [1:0]  y_len;
    logic [7:0]  len1;
    logic [7:0]  len2;
  } msg_t;

  // LEB128 bytes of a value, lowest group in the lowest byte.
  function automatic logic [39:0] vint_bytes(input logic [29:0] v);
    logic [34:0] v_ext;
    logic [39:0] res;
    v_ext = {5'b0, v};
    res = '0;
    for (int k = 0; k < 5; k++) begin
      res[8*k +: 7] = v_ext[7*k +: 7];
      res[8*k + 7]  = ((v_ext >> (7 * (k + 1))) != '0);
    end
    return res;
  endfunction

  function automatic logic [2:0] vint_len(input logic [29:0] v);
    logic [2:0] n;
    n = 3'd1;
    for (int k = 1; k < 5; k++) begin
      if ((v >> (7 * k)) != '0) n = 3'(k + 1);
    end
    return n;
  endfunction

endpackage

/* hw/rtl/tevs_sat.sv */
// Input register stage with coordinate saturation.
module tevs_sat #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tevs_pkg::event_t in_evt,
  output logic             out_valid,
  input  logic             out_ready,
  output tevs_pkg::event_t out_evt
);

  localparam logic [15:0] CoordMax =
    (COORD_BITS >= 16) ? 16'hffff : 16'((32'd1 << COORD_BITS) - 32'd1);

  logic             valid;
  tevs_pkg::event_t evt;
  tevs_pkg::event_t evt_next;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_evt   = evt;

  always_comb begin
    evt_next = in_evt;
    if (in_evt.x_pos > CoordMax) evt_next.x_pos = CoordMax;
    if (in_evt.y_pos > CoordMax) evt_next.y_pos = CoordMax;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      evt <= evt_next;
    end
  end

endmodule

/* hw/rtl/tevs_varint.sv */
// Varint encoding stage: splits timestamp and coordinates into bytes and sizes the message.
module tevs_varint (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tevs_pkg::event_t in_evt,
  output logic             out_valid,
  input  logic             out_ready,
  output tevs_pkg::msg_t   out_msg
);

  logic           valid;
  tevs_pkg::msg_t msg;
  tevs_pkg::msg_t msg_next;
  logic [39:0]    x_full;
  logic [39:0]    y_full;
  logic [7:0]     coord_bytes;

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_msg   = msg;

  always_comb begin
    x_full            = tevs_pkg::vint_bytes({14'b0, in_evt.x_pos});
    y_full            = tevs_pkg::vint_bytes({14'b0, in_evt.y_pos});
    msg_next.action   = in_evt.action;
    msg_next.ts_bytes = tevs_pkg::vint_bytes(in_evt.timestamp_ns);
    msg_next.ts_len   = tevs_pkg::vint_len(in_evt.timestamp_ns);
    msg_next.x_bytes  = x_full[23:0];
    msg_next.x_len    = 2'(tevs_pkg::vint_len({14'b0, in_evt.x_pos}));
    msg_next.y_bytes  = y_full[23:0];
    msg_next.y_len    = 2'(tevs_pkg::vint_len({14'b0, in_evt.y_pos}));
    coord_bytes       = {6'b0, msg_next.x_len} + {6'b0, msg_next.y_len}
                        + tevs_pkg::ZERO_VINT_LEN;
    msg_next.len1     = tevs_pkg::LEN1_BASE + coord_bytes;
    msg_next.len2     = tevs_pkg::LEN2_BASE + coord_bytes;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      msg <= msg_next;
    end
  end

endmodule

/* hw/rtl/tevs_emit.sv */
// Byte sequencer: walks the segments, one byte per cycle into the output register when not stalled.
module tevs_emit (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  tevs_pkg::msg_t in_msg,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,
  output logic           m_tlast
);

  typedef enum logic [6:0] {
    S_HDR  = 7'b0000001,
    S_TS   = 7'b0000010,
    S_MID  = 7'b0000100,
    S_X    = 7'b0001000,
    S_TAGY = 7'b0010000,
    S_Y    = 7'b0100000,
    S_TAIL = 7'b1000000
  } seg_t;

  localparam logic [2:0] HDR_END  = 3'(tevs_pkg::HDR_LEN - 1);
  localparam logic [2:0] MID_END  = 3'(tevs_pkg::MID_LEN - 1);
  localparam logic [2:0] TAIL_END = 3'(tevs_pkg::TAIL_LEN - 1);

  logic           busy;
  seg_t           state;
  seg_t           state_next;
  logic [2:0]     idx;
  tevs_pkg::msg_t desc;
  logic [7:0]     cur_byte;
  logic           seg_end;
  logic           fin;
  logic           advance;
  logic           load;

  assign advance  = busy && (!m_tvalid || m_tready);
  assign fin      = (state == S_TAIL) && (idx == TAIL_END);
  assign in_ready = !busy || (advance && fin);
  assign load     = in_valid && in_ready;

  always_comb begin
    cur_byte   = '0;
    seg_end    = 1'b0;
    state_next = state;
    case (state)
      S_HDR: begin
        cur_byte   = tevs_pkg::HDR_BYTES[idx];
        seg_end    = (idx == HDR_END);
        state_next = S_TS;
      end
      S_TS: begin
        cur_byte   = desc.ts_bytes[7:0];
        seg_end    = (idx == desc.ts_len - 3'd1);
        state_next = S_MID;
      end
      S_MID: begin
        case (idx)
          3'd0:    cur_byte = tevs_pkg::MSG_ID;
          3'd1:    cur_byte = desc.len1;
          3'd2:    cur_byte = tevs_pkg::SUB_ID;
          3'd3:    cur_byte = desc.len2;
          default: cur_byte = tevs_pkg::TAG_X;
        endcase
        seg_end    = (idx == MID_END);
        state_next = S_X;
      end
      S_X: begin
        cur_byte   = desc.x_bytes[7:0];
        seg_end    = (idx == {1'b0, desc.x_len - 2'd1});
        state_next = S_TAGY;
      end
      S_TAGY: begin
        cur_byte   = tevs_pkg::TAG_Y;
        seg_end    = 1'b1;
        state_next = S_Y;
      end
      S_Y: begin
        cur_byte   = desc.y_bytes[7:0];
        seg_end    = (idx == {1'b0, desc.y_len - 2'd1});
        state_next = S_TAIL;
      end
      S_TAIL: begin
        if (idx == TAIL_END) begin
          cur_byte = {6'b0, desc.action};
        end else begin
          cur_byte = tevs_pkg::TAIL_BYTES[idx];
        end
        seg_end    = (idx == TAIL_END);
        state_next = S_HDR;
      end
      default: begin
        cur_byte   = '0;
        seg_end    = 1'b1;
        state_next = S_HDR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      state    <= S_HDR;
      idx      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        busy  <= 1'b1;
        state <= S_HDR;
        idx   <= '0;
      end else if (advance) begin
        if (fin) begin
          busy <= 1'b0;
        end else if (seg_end) begin
          state <= state_next;
          idx   <= '0;
        end else begin
          idx <= idx + 3'd1;
        end
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Varint fields shift down a byte as each of their bytes goes out.
  always_ff @(posedge clk) begin
    if (load) begin
      desc <= in_msg;
    end else if (advance) begin
      if (state == S_TS) desc.ts_bytes <= desc.ts_bytes >> 8;
      if (state == S_X)  desc.x_bytes  <= desc.x_bytes >> 8;
      if (state == S_Y)  desc.y_bytes  <= desc.y_bytes >> 8;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= cur_byte;
      m_tlast <= fin;
    end
  end

  a_load_starts_hdr: assert property (@(posedge clk) disable iff (rst)
    load |=> busy && (state == S_HDR) && (idx == 3'd0))
    else $error("new request did not start at the header");

  a_fin_marks_last: assert property (@(posedge clk) disable iff (rst)
    advance && fin |=> m_tvalid && m_tlast)
    else $error("final byte not marked last");

  a_ts_in_range: assert property (@(posedge clk) disable iff (rst)
    busy && (state == S_TS) |-> idx < desc.ts_len)
    else $error("timestamp byte index beyond varint length");

  a_last_is_action: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[7:2] == 6'd0)
    else $error("last byte is not an action code");

endmodule

/* hw/rtl/touch_event_varint_serializer.sv */
// Top level of the touch event serializer: saturate, varint encode, byte sequencer.
// Each accepted request (one touch event) becomes a message of 22 to 30 bytes on the
// master side, one byte per cycle while m_tready does not stall it, with tlast on the
// final byte. The first byte passes the input register, the encode register, the
// sequencer's message register and the output register, and the next event is taken
// while the last byte of the current one goes out, so messages follow one another
// without gaps. Coordinates above 2^COORD_BITS - 1 saturate to that value.
module touch_event_varint_serializer #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // action[1:0], x_pos[17:2], y_pos[33:18], timestamp_ns[63:34]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte[7:0]
  output logic        m_tlast
);

  tevs_pkg::event_t in_evt;
  tevs_pkg::event_t sat_evt;
  tevs_pkg::msg_t   enc_msg;
  logic             sat_valid;
  logic             sat_ready;
  logic             enc_valid;
  logic             enc_ready;

  assign in_evt.action       = s_tdata[1:0];
  assign in_evt.x_pos        = s_tdata[17:2];
  assign in_evt.y_pos        = s_tdata[33:18];
  assign in_evt.timestamp_ns = s_tdata[63:34];

  tevs_sat #(
    .COORD_BITS (COORD_BITS)
  ) u_sat (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_evt    (in_evt),
    .out_valid (sat_valid),
    .out_ready (sat_ready),
    .out_evt   (sat_evt)
  );

  tevs_varint u_varint (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sat_valid),
    .in_ready  (sat_ready),
    .in_evt    (sat_evt),
    .out_valid (enc_valid),
    .out_ready (enc_ready),
    .out_msg   (enc_msg)
  );

  tevs_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .in_valid (enc_valid),
    .in_ready (enc_ready),
    .in_msg   (enc_msg),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* bench/touch_msg_checker.sv */
`timescale 1ns / 1ps
// Channel monitor that predicts each touch message byte by byte and compares the serializer output.
module touch_msg_checker #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [63:0] s_tdata,   // action[1:0], x_pos[17:2], y_pos[33:18], timestamp_ns[63:34]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [7:0]  m_tdata,   // out_byte[7:0]
  input  logic        m_tlast,
  output int unsigned fail_count,
  output int unsigned outstanding,
  output int unsigned bytes_checked,
  output int unsigned events_seen
);

  localparam logic [55:0] HEADER     = 56'h02_0b_03_00_80_01_08;
  localparam logic [7:0]  MSG_ID     = 8'h1a;
  localparam logic [7:0]  SUB_ID     = 8'h0a;
  localparam logic [7:0]  LEN1_START = 8'h09;
  localparam logic [7:0]  LEN2_START = 8'h03;
  localparam logic [7:0]  TAG_STEP   = 8'h08;
  localparam logic [23:0] POSTAMBLE  = 24'h10_00_18;
  localparam int unsigned MAX_REPORTS = 50;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  msg_byte_t   msg_bytes_q [$];
  int unsigned errs = 0;
  int unsigned n_bytes = 0;
  int unsigned n_events = 0;

  function automatic logic [31:0] saturate(input logic [31:0] v);
    logic [32:0] cmax;
    cmax = (33'd1 << COORD_BITS) - 33'd1;
    return ({1'b0, v} > cmax) ? cmax[31:0] : v;
  endfunction

  function automatic int unsigned varint_len(input logic [31:0] v);
    int unsigned n;
    n = 1;
    while ((v >> (7 * n)) != 0) n++;
    return n;
  endfunction

  // Group k of the varint, with the continuation bit set while higher groups remain.
  function automatic logic [7:0] varint_byte(input logic [31:0] v, input int unsigned k);
    logic [31:0] rest;
    rest = v >> (7 * k);
    return {(rest >> 7) != 0, rest[6:0]};
  endfunction

  function automatic void expect_message(input logic [63:0] req);
    logic [31:0] vals [4];
    logic [7:0]  msg [$];
    logic [7:0]  coord_bytes;
    msg_byte_t   entry;
    vals[0] = {2'b00, req[63:34]};
    vals[1] = saturate({16'h0, req[17:2]});
    vals[2] = saturate({16'h0, req[33:18]});
    vals[3] = '0;
    coord_bytes = 8'(varint_len(vals[1]) + varint_len(vals[2]) + varint_len(vals[3]));
    for (int i = 0; i < 7; i++) msg.push_back(HEADER[8 * (6 - i) +: 8]);
    for (int k = 0; k < varint_len(vals[0]); k++) msg.push_back(varint_byte(vals[0], k));
    msg.push_back(MSG_ID);
    msg.push_back(8'(LEN1_START + coord_bytes));
    msg.push_back(SUB_ID);
    msg.push_back(8'(LEN2_START + coord_bytes));
    for (int f = 1; f <= 3; f++) begin
      msg.push_back(8'(TAG_STEP * f));
      for (int k = 0; k < varint_len(vals[f]); k++) msg.push_back(varint_byte(vals[f], k));
    end
    for (int i = 0; i < 3; i++) msg.push_back(POSTAMBLE[8 * (2 - i) +: 8]);
    msg.push_back({6'b0, req[1:0]});
    foreach (msg[i]) begin
      entry.data = msg[i];
      entry.last = (i == msg.size() - 1);
      msg_bytes_q.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin
    msg_byte_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        expect_message(s_tdata);
        n_events++;
      end
      if (m_tvalid && m_tready) begin
        if (msg_bytes_q.size() == 0) begin
          errs++;
          if (errs <= MAX_REPORTS)
            $display("%0t: unexpected byte: expected none, got data %h last %b",
                     $time, m_tdata, m_tlast);
        end else begin
          want = msg_bytes_q.pop_front();
          n_bytes++;
          if (m_tdata !== want.data) begin
            errs++;
            if (errs <= MAX_REPORTS)
              $display("%0t: byte %0d data mismatch: expected %h, got %h",
                       $time, n_bytes, want.data, m_tdata);
          end
          if (m_tlast !== want.last) begin
            errs++;
            if (errs <= MAX_REPORTS)
              $display("%0t: byte %0d last mismatch: expected %b, got %b",
                       $time, n_bytes, want.last, m_tlast);
          end
        end
      end
    end
    fail_count    <= errs;
    outstanding   <= msg_bytes_q.size();
    bytes_checked <= n_bytes;
    events_seen   <= n_events;
  end

endmodule

/* bench/tb_touch_event_varint_serializer.sv */
`timescale 1ns / 1ps
// Testbench top for the touch event serializer: clock, reset, request stimulus and verdict.
module tb_touch_event_varint_serializer;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned PHASE_EVENTS   = 50;
  localparam int unsigned DRAIN_CYCLES   = 40;

  typedef enum int unsigned {RX_ALWAYS, RX_LIGHT, RX_PERIODIC, RX_HEAVY} rx_mode_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [63:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tlast;

  int unsigned fail_count;
  int unsigned outstanding;
  int unsigned bytes_checked;
  int unsigned events_seen;
  int unsigned events_sent = 0;
  int unsigned idle_count = 0;
  int unsigned stall_phase = 0;
  rx_mode_t    rx_mode = RX_ALWAYS;

  touch_event_varint_serializer #(.COORD_BITS(16)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  touch_msg_checker #(.COORD_BITS(16)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tlast       (m_tlast),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .bytes_checked (bytes_checked),
    .events_seen   (events_seen)
  );

  always #5 clk = ~clk;

  // Each receiver mode gives a different stall pattern on the byte stream.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    case (rx_mode)
      RX_ALWAYS: begin
        m_tready <= 1'b1;
      end
      RX_LIGHT: begin
        m_tready <= ($urandom_range(3) != 0);
      end
      RX_PERIODIC: begin
        m_tready <= ((stall_phase % 7) >= 2);
      end
      default: begin
        m_tready <= ($urandom_range(9) < 3);
      end
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, nothing accepted for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic push_event(input logic [1:0] act, input logic [15:0] x,
                            input logic [15:0] y, input logic [29:0] ts);
    s_tdata  <= {ts, y, x, act};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    events_sent++;
  endtask

  task automatic pause_sender(input int unsigned cycles);
    if (cycles > 0) begin
      s_tvalid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Mostly picks a random bit length first so that every varint length shows up often.
  function automatic logic [31:0] rand_field(input int unsigned nbits);
    int unsigned span;
    span = $urandom_range(nbits, 1);
    if ($urandom_range(3) == 0) return $urandom >> (32 - nbits);
    return $urandom >> (32 - span);
  endfunction

  function automatic logic [1:0] rand_action();
    if ($urandom_range(9) == 0) return 2'd3;
    return 2'($urandom_range(2));
  endfunction

  task automatic send_random(input int unsigned count, input int unsigned max_burst,
                             input int unsigned max_gap);
    int unsigned left;
    int unsigned burst;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(max_burst, 1);
      if (burst > left) burst = left;
      repeat (burst)
        push_event(rand_action(), 16'(rand_field(16)), 16'(rand_field(16)),
                   30'(rand_field(30)));
      left -= burst;
      if (left > 0) pause_sender($urandom_range(max_gap, 0));
    end
  endtask

  initial begin
    clk      = 1'b0;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    rx_mode = RX_PERIODIC;
    @(posedge clk);

    // Varint length boundaries on every field, all action codes, timestamps past one second.
    push_event(2'd0, 16'd0, 16'd0, 30'd0);
    push_event(2'd1, 16'd127, 16'd127, 30'd127);
    push_event(2'd2, 16'd128, 16'd128, 30'd128);
    push_event(2'd3, 16'd16383, 16'd16384, 30'd16383);
    push_event(2'd0, 16'd16384, 16'd16383, 30'd16384);
    push_event(2'd1, 16'd65535, 16'd0, 30'd2097151);
    push_event(2'd2, 16'd0, 16'd65535, 30'd2097152);
    push_event(2'd3, 16'd65535, 16'd65535, 30'd268435455);
    push_event(2'd0, 16'd255, 16'd256, 30'd268435456);
    push_event(2'd1, 16'd1, 16'd2, 30'd999999999);
    push_event(2'd2, 16'haaaa, 16'h5555, 30'd1000000000);
    push_event(2'd3, 16'h5555, 16'haaaa, 30'h2aaaaaaa);
    push_event(2'd1, 16'haaaa, 16'haaaa, 30'h15555555);
    push_event(2'd0, 16'd65535, 16'd65535, 30'h3fffffff);
    push_event(2'd2, 16'd0, 16'd0, 30'h3fffffff);
    wait_drained();

    rx_mode = RX_ALWAYS;
    send_random(PHASE_EVENTS, PHASE_EVENTS, 0);
    wait_drained();
    rx_mode = RX_LIGHT;
    send_random(PHASE_EVENTS, 8, 6);
    wait_drained();
    rx_mode = RX_PERIODIC;
    send_random(PHASE_EVENTS, 4, 12);
    wait_drained();
    rx_mode = RX_HEAVY;
    send_random(PHASE_EVENTS, 6, 3);
    wait_drained();
    rx_mode = RX_ALWAYS;
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d touch events sent, %0d seen by the checker, %0d bytes compared.",
             events_sent, events_seen, bytes_checked);
    $display("Summary: all action codes, varints of one to five bytes, four stall patterns.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/tevs_pkg.sv
hw/rtl/tevs_sat.sv
hw/rtl/tevs_varint.sv
hw/rtl/tevs_emit.sv
hw/rtl/touch_event_varint_serializer.sv
bench/touch_msg_checker.sv
bench/tb_touch_event_varint_serializer.sv
